[rtl/core/dqcd_pkg.sv]
// Package for the dual quadrature cell-distance counter.
// Holds widths, register indexes, reset values and the word types.
// No dependencies; every other file in rtl/core imports it.
`default_nettype none

package dqcd_pkg;

	// Core widths.
	localparam int COUNT_WIDTH  = 16;
	localparam int FILTER_WIDTH = 10;

	// Register widths and the configuration port.
	localparam int TICKS_W   = 15;
	localparam int TOL_W     = 10;
	localparam int GLITCH_W  = 10;
	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W     = 16;

	// Width for signed compares against the register values.
	localparam int CMP_W = ((COUNT_WIDTH > TICKS_W + 1) ? COUNT_WIDTH : TICKS_W + 1) + 2;
	// Width for the filter sample count against glitch_cycles.
	localparam int GW = ((FILTER_WIDTH > GLITCH_W) ? FILTER_WIDTH : GLITCH_W) + 1;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TICKS_PER_CELL  = 2'd0,
		REG_WATCH_TOLERANCE = 2'd1,
		REG_GLITCH_CYCLES   = 2'd2
	} cfg_reg_t;

	// Register reset values.
	localparam logic [TICKS_W-1:0]  TICKS_RESET  = 15'd1180;
	localparam logic [TOL_W-1:0]    TOL_RESET    = 10'd16;
	localparam logic [GLITCH_W-1:0] GLITCH_RESET = 10'd80;

	// Count limits, one bit wider than a count.
	localparam logic signed [COUNT_WIDTH:0] CNT_MAX_X = {2'b00, {(COUNT_WIDTH-1){1'b1}}};
	localparam logic signed [COUNT_WIDTH:0] CNT_MIN_X = {2'b11, {(COUNT_WIDTH-1){1'b0}}};

	typedef logic signed [COUNT_WIDTH-1:0] cnt_t;
	typedef logic signed [CMP_W-1:0]       cmp_t;

	// Input word: one sample of both encoders plus the control bits.
	typedef struct packed {
		logic left_a;
		logic left_b;
		logic right_a;
		logic right_b;
		logic clear_cell;
		logic poll;
	} in_word_t;

	// Result word.
	typedef struct packed {
		logic signed [OUT_W-1:0] left_count;
		logic signed [OUT_W-1:0] right_count;
		logic signed [OUT_W-1:0] mean_distance;
		logic                    cell_reached;
		logic                    watch_hit;
	} out_word_t;

	// What one wheel lane hands to the merge stage.
	typedef struct packed {
		cnt_t count_pre;
	} lane_stat_t;

	// Thresholds derived from the registers.
	typedef struct packed {
		cmp_t target;
		cmp_t thr;
		cmp_t ticks;
	} cfg_view_t;

endpackage

`default_nettype wire

[rtl/core/dqcd_if.sv]
// Valid/ready channel interfaces for the sample and result words.
// Depends on dqcd_pkg for the word types.
`default_nettype none

interface dqcd_in_if import dqcd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dqcd_out_if import dqcd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/core/dqcd_filter.sv]
// Glitch filter for one encoder level: a new level is taken once it has held.
// Depends on dqcd_pkg for the filter and register widths.
`default_nettype none

module dqcd_filter import dqcd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                raw,
	input  wire logic [GLITCH_W-1:0] glitch_cycles,
	output logic                     level_old,
	output logic                     level_new
);

	logic                    level_q;
	logic [FILTER_WIDTH-1:0] timer_q;
	logic [FILTER_WIDTH-1:0] timer_d;
	logic [GW-1:0]           samples;
	logic                    take;

	// Sample count for the pending level, and the acceptance decision.
	always_comb begin
		samples = GW'(timer_q) + GW'(1'b1);
		take    = (&timer_q) || (samples >= GW'(glitch_cycles));
		if (raw == level_q) begin
			level_new = level_q;
			timer_d   = '0;
		end else if (take) begin
			level_new = raw;
			timer_d   = '0;
		end else begin
			level_new = level_q;
			timer_d   = samples[FILTER_WIDTH-1:0];
		end
	end

	assign level_old = level_q;

	// Filter state advances once per accepted word.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= 1'b0;
			timer_q <= '0;
		end else if (en) begin
			level_q <= level_new;
			timer_q <= timer_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dqcd_lane.sv]
// One wheel lane: filters for A and B and the x2 quadrature up/down counter.
// Depends on dqcd_pkg and dqcd_filter.
`default_nettype none

module dqcd_lane import dqcd_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                clear,
	input  wire logic                raw_a,
	input  wire logic                raw_b,
	input  wire logic [GLITCH_W-1:0] glitch_cycles,
	output lane_stat_t               stat
);

	logic a_old, a_new, b_old, b_new;
	logic inc, dec;
	logic signed [COUNT_WIDTH:0] sum;
	cnt_t count_q;
	cnt_t count_pre;

	dqcd_filter u_filt_a (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.raw           (raw_a),
		.glitch_cycles (glitch_cycles),
		.level_old     (a_old),
		.level_new     (a_new)
	);

	dqcd_filter u_filt_b (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (en),
		.raw           (raw_b),
		.glitch_cycles (glitch_cycles),
		.level_old     (b_old),
		.level_new     (b_new)
	);

	// Edge of filtered A sets the step; filtered B after this sample sets direction.
	always_comb begin
		inc = (!a_old && a_new && b_new) || (a_old && !a_new && !b_new);
		dec = (!a_old && a_new && !b_new) || (a_old && !a_new && b_new);
		sum = {count_q[COUNT_WIDTH-1], count_q};
		if (inc) begin
			sum = sum + (COUNT_WIDTH+1)'(1);
		end else if (dec) begin
			sum = sum - (COUNT_WIDTH+1)'(1);
		end
		// A count that reaches either limit returns to zero.
		if ((inc || dec) && (sum >= CNT_MAX_X || sum <= CNT_MIN_X)) begin
			count_pre = '0;
		end else begin
			count_pre = sum[COUNT_WIDTH-1:0];
		end
	end

	assign stat.count_pre = count_pre;

	// Count register; a cell clear overrides this sample's step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (en) begin
			count_q <= clear ? cnt_t'(0) : count_pre;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dqcd_merge.sv]
// Merge stage: watch flag, mean of both counts and the cell-reached decision.
// Depends on dqcd_pkg for the lane, threshold and result types.
`default_nettype none

module dqcd_merge import dqcd_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire logic       clear,
	input  wire logic       poll,
	input  wire cfg_view_t  cfg,
	input  wire lane_stat_t left,
	input  wire lane_stat_t right,
	output out_word_t       result
);

	logic watch_q;
	logic watch_mid, watch_d;
	logic hit, reached;
	cnt_t left_cnt, right_cnt, mean;
	logic signed [COUNT_WIDTH:0] sum;
	logic signed [COUNT_WIDTH:0] sum_adj;
	cmp_t mean_x;

	always_comb begin
		// Watch latch sees the counts before a clear.
		hit = (cmp_t'(left.count_pre) == cfg.target)
			|| (cmp_t'(right.count_pre) == cfg.target);
		watch_mid = clear ? 1'b0 : (watch_q || hit);
		left_cnt  = clear ? cnt_t'(0) : left.count_pre;
		right_cnt = clear ? cnt_t'(0) : right.count_pre;

		// Mean truncated toward zero: add one to a negative sum before the shift.
		sum     = (COUNT_WIDTH+1)'(left_cnt) + (COUNT_WIDTH+1)'(right_cnt);
		sum_adj = sum + (COUNT_WIDTH+1)'(sum[COUNT_WIDTH]);
		mean    = sum_adj[COUNT_WIDTH:1];
		mean_x  = cmp_t'(mean);

		reached = (watch_mid && mean_x >= cfg.thr) || (mean_x >= cfg.ticks);
		// A poll that finds the cell not reached drops the flag.
		watch_d = (poll && !reached) ? 1'b0 : watch_mid;

		result.left_count    = OUT_W'(left_cnt);
		result.right_count   = OUT_W'(right_cnt);
		result.mean_distance = OUT_W'(mean);
		result.cell_reached  = reached;
		result.watch_hit     = watch_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watch_q <= 1'b0;
		end else if (en) begin
			watch_q <= watch_d;
		end
	end

endmodule

`default_nettype wire

[rtl/core/dual_quadrature_cell_distance.sv]
// Top level of the dual quadrature cell-distance counter.
// Depends on dqcd_pkg, dqcd_if, dqcd_lane and dqcd_merge.
//
//   channel   dir  handshake          word
//   samples   in   valid/ready        in_word_t: four encoder levels, clear_cell, poll
//   results   out  valid/ready        out_word_t: both counts, mean, cell_reached, watch_hit
//   cfg       in   cfg_we, no wait    cfg_index selects a register, cfg_data its value
//
// One sample word is taken every cycle while the skid entry is empty; its result
// word is registered in the output buffer. Filters, counters and the watch flag
// update in the cycle the sample is taken, so successive samples follow without
// gaps. A two-entry output buffer lets the block take a sample while an earlier
// result waits; samples are refused only when both entries are full. Reset clears
// all state and restores the register reset values.
`default_nettype none

module dual_quadrature_cell_distance import dqcd_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	dqcd_in_if.sink                   samples,
	dqcd_out_if.source                results,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic [TICKS_W-1:0]  ticks_q;
	logic [TOL_W-1:0]    tol_q;
	logic [GLITCH_W-1:0] glitch_q;
	cfg_view_t           cfg_view;
	lane_stat_t          left_stat, right_stat;
	out_word_t           result;
	out_word_t           out_q, skid_q;
	logic                out_valid_q, skid_valid_q;
	logic                accept;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q  <= TICKS_RESET;
			tol_q    <= TOL_RESET;
			glitch_q <= GLITCH_RESET;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_TICKS_PER_CELL:  ticks_q  <= cfg_data[TICKS_W-1:0];
				REG_WATCH_TOLERANCE: tol_q    <= cfg_data[TOL_W-1:0];
				REG_GLITCH_CYCLES:   glitch_q <= cfg_data[GLITCH_W-1:0];
				default: ;
			endcase
		end
	end

	// Target clamped inside the count range, and the tolerance threshold.
	always_comb begin
		cfg_view.ticks = cmp_t'(ticks_q);
		cfg_view.thr   = cmp_t'(ticks_q) - cmp_t'(tol_q);
		if (cfg_view.ticks > cmp_t'(CNT_MAX_X) - cmp_t'(1)) begin
			cfg_view.target = cmp_t'(CNT_MAX_X) - cmp_t'(1);
		end else if (cfg_view.ticks < cmp_t'(CNT_MIN_X) + cmp_t'(1)) begin
			cfg_view.target = cmp_t'(CNT_MIN_X) + cmp_t'(1);
		end else begin
			cfg_view.target = cfg_view.ticks;
		end
	end

	assign samples.ready = !skid_valid_q;
	assign accept        = samples.valid && samples.ready;

	// One lane per wheel.
	dqcd_lane u_lane_left (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (accept),
		.clear         (samples.data.clear_cell),
		.raw_a         (samples.data.left_a),
		.raw_b         (samples.data.left_b),
		.glitch_cycles (glitch_q),
		.stat          (left_stat)
	);

	dqcd_lane u_lane_right (
		.clk           (clk),
		.arst_n        (arst_n),
		.en            (accept),
		.clear         (samples.data.clear_cell),
		.raw_a         (samples.data.right_a),
		.raw_b         (samples.data.right_b),
		.glitch_cycles (glitch_q),
		.stat          (right_stat)
	);

	dqcd_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (accept),
		.clear  (samples.data.clear_cell),
		.poll   (samples.data.poll),
		.cfg    (cfg_view),
		.left   (left_stat),
		.right  (right_stat),
		.result (result)
	);

	// Output buffer control: head entry plus one skid entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_valid_q && results.ready) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= accept;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end
	end

	// Output buffer words.
	always_ff @(posedge clk) begin
		if (out_valid_q && results.ready) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			if (out_valid_q) begin
				skid_q <= result;
			end else begin
				out_q <= result;
			end
		end
	end

	assign results.valid = out_valid_q;
	assign results.data  = out_q;

endmodule

`default_nettype wire

[test/cell_distance_checker.sv]
// Checker for the dual quadrature cell-distance counter.
// Watches the sample, result and register ports, predicts every result word and compares.
// Depends on dqcd_pkg and the channel interfaces in dqcd_if.
module cell_distance_checker import dqcd_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	dqcd_in_if                   samples,
	dqcd_out_if                  results,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   mismatches,
	output int                   pending,
	output int                   checked,
	output int                   reached_seen,
	output int                   watch_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CNT_HI = (1 << (COUNT_WIDTH - 1)) - 1;
	localparam int CNT_LO = -CNT_HI - 1;
	localparam int REPORT_LIMIT = 10;

	// Register copies.
	logic [TICKS_W-1:0]  ticks;
	logic [TOL_W-1:0]    tolerance;
	logic [GLITCH_W-1:0] glitch;

	// Predicted block state: levels are left A, left B, right A, right B from bit 0 up.
	logic [3:0]              level;
	logic [FILTER_WIDTH-1:0] settle [4];
	cnt_t                    wheel [2];
	logic                    watch;

	out_word_t expected_results [$];
	int        fail_total;
	int        checked_total;
	int        reached_total;
	int        watch_total;

	// One x2 quadrature update of a wheel count, with the return to zero at the limits.
	function automatic cnt_t wheel_step(cnt_t c, logic a_old, logic a_new, logic b);
		int d;
		int n;
		d = 0;
		if (!a_old && a_new)
			d = b ? 1 : -1;
		else if (a_old && !a_new)
			d = b ? -1 : 1;
		if (d == 0)
			return c;
		n = int'(c) + d;
		if (n >= CNT_HI || n <= CNT_LO)
			n = 0;
		return cnt_t'(n);
	endfunction

	// Advance the predicted state by one sample word and return the result word it causes.
	function automatic out_word_t predict_result(in_word_t w);
		logic [3:0] raw;
		logic [3:0] prev;
		int         target;
		int         mean;
		int         thr;
		logic       reached;
		out_word_t  r;

		raw  = {w.right_b, w.right_a, w.left_b, w.left_a};
		prev = level;

		// Glitch filters: a new level must show for glitch samples in a row.
		for (int i = 0; i < 4; i++) begin
			if (raw[i] == level[i]) begin
				settle[i] = '0;
			end else if (settle[i] == {FILTER_WIDTH{1'b1}} ||
					int'(settle[i]) + 1 >= int'(glitch)) begin
				level[i]  = ~level[i];
				settle[i] = '0;
			end else begin
				settle[i] = settle[i] + 1'b1;
			end
		end

		wheel[0] = wheel_step(wheel[0], prev[0], level[0], level[1]);
		wheel[1] = wheel_step(wheel[1], prev[2], level[2], level[3]);

		// Watch target is the cell length clamped inside the count range.
		target = int'(ticks);
		if (target > CNT_HI - 1)
			target = CNT_HI - 1;
		if (target < CNT_LO + 1)
			target = CNT_LO + 1;
		if (int'(wheel[0]) == target || int'(wheel[1]) == target)
			watch = 1'b1;

		if (w.clear_cell) begin
			wheel[0] = '0;
			wheel[1] = '0;
			watch    = 1'b0;
		end

		mean    = (int'(wheel[0]) + int'(wheel[1])) / 2;
		thr     = int'(ticks) - int'(tolerance);
		reached = (watch && mean >= thr) || mean >= int'(ticks);

		// A poll that finds no cell reached drops the watch flag.
		if (w.poll && !reached)
			watch = 1'b0;

		r.left_count    = wheel[0];
		r.right_count   = wheel[1];
		r.mean_distance = OUT_W'(mean);
		r.cell_reached  = reached;
		r.watch_hit     = watch;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		out_word_t got;
		out_word_t want;
		logic      bad;
		if (!arst_n) begin
			ticks     = TICKS_RESET;
			tolerance = TOL_RESET;
			glitch    = GLITCH_RESET;
			level     = '0;
			foreach (settle[i])
				settle[i] = '0;
			wheel[0] = '0;
			wheel[1] = '0;
			watch    = 1'b0;
			expected_results.delete();
			fail_total    = 0;
			checked_total = 0;
			reached_total = 0;
			watch_total   = 0;
		end else begin
			// Results are matched first, so a word cannot pair with a sample of this edge.
			if (results.valid === 1'b1 && results.ready === 1'b1) begin
				got = results.data;
				if (expected_results.size() == 0) begin
					fail_total++;
					if (fail_total <= REPORT_LIMIT)
						$display("%t: unexpected result L=%0d R=%0d M=%0d c=%0b w=%0b",
							$realtime, got.left_count, got.right_count,
							got.mean_distance, got.cell_reached, got.watch_hit);
				end else begin
					want = expected_results.pop_front();
					bad  = (got.left_count !== want.left_count) ||
						(got.right_count !== want.right_count) ||
						(got.mean_distance !== want.mean_distance) ||
						(got.cell_reached !== want.cell_reached) ||
						(got.watch_hit !== want.watch_hit);
					checked_total++;
					if (want.cell_reached)
						reached_total++;
					if (want.watch_hit)
						watch_total++;
					if (bad) begin
						fail_total++;
						if (fail_total <= REPORT_LIMIT) begin
							$display("%t: mismatch: expected L=%0d R=%0d M=%0d c=%0b w=%0b",
								$realtime, want.left_count, want.right_count,
								want.mean_distance, want.cell_reached, want.watch_hit);
							$display("%t: mismatch: got      L=%0d R=%0d M=%0d c=%0b w=%0b",
								$realtime, got.left_count, got.right_count,
								got.mean_distance, got.cell_reached, got.watch_hit);
						end
					end
				end
			end

			// A sample taken at this edge still sees the old register values.
			if (samples.valid === 1'b1 && samples.ready === 1'b1)
				expected_results.push_back(predict_result(samples.data));

			// Register writes, masked to the register widths; they apply after this edge.
			if (cfg_we === 1'b1) begin
				case (cfg_index)
					REG_TICKS_PER_CELL:  ticks     = cfg_data[TICKS_W-1:0];
					REG_WATCH_TOLERANCE: tolerance = cfg_data[TOL_W-1:0];
					REG_GLITCH_CYCLES:   glitch    = cfg_data[GLITCH_W-1:0];
					default: ;
				endcase
			end
		end
		mismatches   <= fail_total;
		pending      <= expected_results.size();
		checked      <= checked_total;
		reached_seen <= reached_total;
		watch_seen   <= watch_total;
	end

endmodule

[test/tb_dual_quadrature_cell_distance.sv]
// Testbench top for the dual quadrature cell-distance counter: clock, reset,
// encoder sample stimulus, result back-pressure, register phases and the verdict.
// Depends on dqcd_pkg, dqcd_if, the block and cell_distance_checker.
module tb_dual_quadrature_cell_distance;
	import dqcd_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int DRAIN_CYCLES   = 20;

	// Directed words: {left_a, left_b, right_a, right_b, clear_cell, poll}.
	localparam logic [5:0] DIRECTED [23] = '{
		// Reset settings: the long filter holds every level back.
		6'b111110, 6'b000001,
		// Immediate filter, target 2, tolerance 1.
		6'b000000, 6'b111111, 6'b101100, 6'b001100, 6'b011100, 6'b111100,
		6'b111101, 6'b110100, 6'b110101, 6'b110000, 6'b111000, 6'b111010,
		6'b011000, 6'b001000, 6'b101000,
		// Filter of three, tolerance above the target.
		6'b001000, 6'b101000, 6'b001000, 6'b001000, 6'b001000, 6'b001001
	};

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	bit tx_idle_en;
	bit rx_idle_en;
	bit pressure_req;
	int settings_used;
	int wheel_pos_l;
	int wheel_pos_r;

	int mismatches;
	int pending;
	int checked;
	int reached_seen;
	int watch_seen;

	dqcd_in_if  sample_ch ();
	dqcd_out_if result_ch ();

	dual_quadrature_cell_distance dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (sample_ch),
		.results   (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	cell_distance_checker checker_inst (
		.clk          (clk),
		.arst_n       (arst_n),
		.samples      (sample_ch),
		.results      (result_ch),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending),
		.checked      (checked),
		.reached_seen (reached_seen),
		.watch_seen   (watch_seen)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// A and B levels of a wheel at a quadrature position; stepping up counts forward.
	function automatic logic [1:0] quad_levels(int pos);
		case (pos % 4)
			0:       return 2'b01;
			1:       return 2'b11;
			2:       return 2'b10;
			default: return 2'b00;
		endcase
	endfunction

	// Offer one sample word, with an occasional idle burst first, and wait for its acceptance.
	task automatic put_word(input in_word_t w);
		if (tx_idle_en && $urandom_range(0, 4) == 0) begin
			sample_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		sample_ch.valid <= 1'b1;
		sample_ch.data  <= w;
		do @(posedge clk); while (sample_ch.ready !== 1'b1);
	endtask

	// Lower valid and wait until every predicted result word has come back.
	task automatic finish_and_drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Write all three registers on consecutive edges; spare data bits carry noise.
	task automatic load_settings(input int t, input int tol, input int g);
		cfg_we    <= 1'b1;
		cfg_index <= REG_TICKS_PER_CELL;
		cfg_data  <= CFG_W'(t);
		@(posedge clk);
		cfg_index <= REG_WATCH_TOLERANCE;
		cfg_data  <= {5'($urandom), TOL_W'(tol)};
		@(posedge clk);
		cfg_index <= REG_GLITCH_CYCLES;
		cfg_data  <= {5'($urandom), GLITCH_W'(g)};
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_directed(input int first, input int last);
		for (int i = first; i <= last; i++)
			put_word(in_word_t'(DIRECTED[i]));
		finish_and_drain();
	endtask

	// One register setting followed by a random walk of both wheels. Each wheel steps
	// after a random hold; single words may carry a one-sample glitch or random noise.
	task automatic run_phase(input int t, input int tol, input int g, input int n,
			input int hold_lo, input int hold_hi, input int fwd_l, input int fwd_r,
			input int glitch_pct, input int noise_pct, input int clear_pct,
			input int poll_pct);
		int         wait_l;
		int         wait_r;
		logic [3:0] lv;
		in_word_t   w;
		load_settings(t, tol, g);
		wait_l = $urandom_range(hold_lo, hold_hi);
		wait_r = $urandom_range(hold_lo, hold_hi);
		for (int i = 0; i < n; i++) begin
			wait_l--;
			wait_r--;
			if (wait_l <= 0) begin
				wheel_pos_l = ($urandom_range(1, 100) <= fwd_l) ? wheel_pos_l + 1
					: wheel_pos_l + 3;
				wheel_pos_l = wheel_pos_l % 4;
				wait_l = $urandom_range(hold_lo, hold_hi);
			end
			if (wait_r <= 0) begin
				wheel_pos_r = ($urandom_range(1, 100) <= fwd_r) ? wheel_pos_r + 1
					: wheel_pos_r + 3;
				wheel_pos_r = wheel_pos_r % 4;
				wait_r = $urandom_range(hold_lo, hold_hi);
			end
			lv = {quad_levels(wheel_pos_l), quad_levels(wheel_pos_r)};
			if ($urandom_range(1, 100) <= noise_pct)
				lv = 4'($urandom);
			else if ($urandom_range(1, 100) <= glitch_pct)
				lv[$urandom_range(0, 3)] ^= 1'b1;
			w.left_a     = lv[3];
			w.left_b     = lv[2];
			w.right_a    = lv[1];
			w.right_b    = lv[0];
			w.clear_cell = ($urandom_range(1, 100) <= clear_pct);
			w.poll       = ($urandom_range(1, 100) <= poll_pct);
			put_word(w);
		end
		finish_and_drain();
	endtask

	// Result side: ready with random idle bursts, and one long hold-off on request.
	initial begin : receiver
		int hold;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (pressure_req) begin
				pressure_req = 1'b0;
				result_ch.ready <= 1'b0;
				hold = $urandom_range(80, 120);
				repeat (hold) @(posedge clk);
			end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
				result_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				result_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	// Ends the run when no word moves on either channel for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1) ||
					(result_ch.valid === 1'b1 && result_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("tb_dual_quadrature_cell_distance NOT OK");
		$finish;
	end

	initial begin : stimulus
		int g_mid;
		arst_n          <= 1'b0;
		sample_ch.valid <= 1'b0;
		sample_ch.data  <= '0;
		cfg_we          <= 1'b0;
		cfg_index       <= REG_TICKS_PER_CELL;
		cfg_data        <= '0;
		tx_idle_en    = 1'b1;
		rx_idle_en    = 1'b1;
		pressure_req  = 1'b0;
		settings_used = 0;
		wheel_pos_l   = 3;
		wheel_pos_r   = 3;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: reset settings, then hand-made edge sequences.
		send_directed(0, 1);
		load_settings(2, 1, 0);
		send_directed(2, 16);
		load_settings(1, 1023, 3);
		send_directed(17, 22);

		// Random walks over a spread of settings.
		run_phase(1, 0, 0, 150, 1, 3, 70, 70, 5, 5, 2, 20);
		run_phase($urandom_range(3, 20), $urandom_range(0, 5), 1, 150, 1, 4, 80, 60,
			5, 5, 2, 25);
		run_phase($urandom_range(5, 30), 1023, 2, 150, 2, 5, 75, 75, 8, 5, 1, 30);
		g_mid = $urandom_range(3, 6);
		run_phase($urandom_range(2, 15), $urandom_range(0, 1023), g_mid, 200, g_mid,
			g_mid + 3, 80, 70, 5, 3, 1, 25);

		// The result side holds off while samples keep coming, so the block backs up.
		tx_idle_en   = 1'b0;
		pressure_req = 1'b1;
		run_phase($urandom_range(1, 40), $urandom_range(0, 20), 0, 250, 1, 2, 85, 40,
			3, 3, 1, 20);
		tx_idle_en = 1'b1;

		// Mostly broken sequences with any cell length.
		run_phase($urandom_range(1, 32767), $urandom_range(0, 1023), $urandom_range(0, 3),
			150, 1, 4, 50, 50, 20, 30, 5, 50);
		// Both wheels running backward.
		run_phase($urandom_range(2, 30), $urandom_range(0, 8), 0, 150, 1, 3, 25, 20,
			5, 5, 2, 20);
		// Long filter: a level passes only after holding the full count.
		run_phase(16, 4, 40, 150, 40, 43, 100, 0, 0, 0, 0, 10);

		// Last part, no idling: left runs up and right down, with the cell length
		// above the count range so the target is clamped.
		tx_idle_en = 1'b0;
		rx_idle_en = 1'b0;
		run_phase(32767, 0, 0, 150, 1, 1, 100, 0, 0, 0, 0, 5);

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d result words over %0d register settings.",
			checked, settings_used);
		$display("Cell reached was predicted %0d times and the watch flag held %0d times.",
			reached_seen, watch_seen);
		if (mismatches == 0)
			$display("tb_dual_quadrature_cell_distance OK");
		else
			$display("tb_dual_quadrature_cell_distance NOT OK");
		$finish;
	end

endmodule
